FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GTG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GTG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GTG_ASSERT_IMP(lbl, ante, cons)
`define GTG_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/gtg_pkg.sv
// ---------------------------------------------------------------------------
// gtg_pkg
// Types, constants and weight tables of the greyscale converter.
// ---------------------------------------------------------------------------
package gtg_pkg;

  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned MAP_DEPTH       = 256;
  localparam int unsigned MAP_AW          = $clog2(MAP_DEPTH);

  localparam int unsigned WEIGHT_SCALE = 1000;
  localparam int unsigned W_RED        = 299;
  localparam int unsigned W_GREEN      = 587;
  localparam int unsigned W_BLUE       = 114;

  // floor(s/1000) == (s*RECIP_K) >> RECIP_SH, exact for s < 2^18
  localparam int unsigned SUM_W    = 18;
  localparam int unsigned RECIP_SH = 28;
  localparam int unsigned RECIP_W  = 19;
  localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'((1 << RECIP_SH) / WEIGHT_SCALE + 1);
  localparam int unsigned PROD_W   = SUM_W + RECIP_W;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic        REG_IDX_SOURCE_FORMAT = 1'b0;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_CONVERT = 1'b1;

  typedef enum logic [1:0] {
    FMT_INDEXED = 2'd0,
    FMT_RGB565  = 2'd1,
    FMT_BGRA    = 2'd2,
    FMT_UNDEF   = 2'd3
  } src_fmt_t;

  typedef enum logic [1:0] {
    K_NONE   = 2'd0,
    K_LOAD   = 2'd1,
    K_DIRECT = 2'd2,
    K_INDEX  = 2'd3
  } item_kind_t;

  typedef struct packed {
    logic              en;
    logic [MAP_AW-1:0] addr;
    logic [7:0]        data;
  } map_wr_t;

  typedef struct packed {
    logic              en;
    logic [MAP_AW-1:0] addr;
  } map_rd_t;

  typedef logic [7:0] wtbl_t [256];

  function automatic wtbl_t build_wtbl(input int unsigned w);
    wtbl_t t;
    for (int unsigned i = 0; i < 256; i++) begin
      t[i] = 8'((i * w) / WEIGHT_SCALE);
    end
    return t;
  endfunction

  localparam wtbl_t RED_TBL   = build_wtbl(W_RED);
  localparam wtbl_t GREEN_TBL = build_wtbl(W_GREEN);
  localparam wtbl_t BLUE_TBL  = build_wtbl(W_BLUE);

endpackage

FILE: rtl/core/gtg_in_if.sv
// ---------------------------------------------------------------------------
// gtg_in_if
// Input channel: palette loads and pixels, valid/ready handshake.
// ---------------------------------------------------------------------------
interface gtg_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] pixel;
  logic [7:0]  entry_index;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  modport source (output valid, func, pixel, entry_index, red, green, blue, input ready);
  modport sink   (input valid, func, pixel, entry_index, red, green, blue, output ready);
endinterface

FILE: rtl/core/gtg_out_if.sv
// ---------------------------------------------------------------------------
// gtg_out_if
// Result channel: grey level, valid/ready handshake.
// ---------------------------------------------------------------------------
interface gtg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] grey;

  modport source (output valid, grey, input ready);
  modport sink   (input valid, grey, output ready);
endinterface

FILE: rtl/core/pixel_to_greyscale_converter.sv
// Two register stages: an accepted item passes stage 1, then the output register.
// Throughput: one item per cycle unless the output stalls; the map memory port (one read, one
// write) sets it. Loads write the map from stage 1 and are forwarded to a following pixel.
// Reset (synchronous, rst_n low) clears all map valid bits at once, so every entry
// reads zero, and sets source_format to 2; no clearing pass is needed.
// ---------------------------------------------------------------------------
// pixel_to_greyscale_converter
// Converts indexed, RGB565 or BGR(A) pixels to 8-bit grey with BT.601 weights.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pixel_to_greyscale_converter (
  input  logic                           clk,
  input  logic                           rst_n,
  gtg_in_if.sink                         in_chan,
  gtg_out_if.source                      out_chan,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gtg_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import gtg_pkg::*;

  src_fmt_t   fmt;
  logic       adv;
  logic       acc;
  item_kind_t kind;
  logic [7:0] r8, g8, b8;
  logic [8:0] direct_sum;
  logic [SUM_W-1:0]  load_sum;
  logic [PROD_W-1:0] prod;
  logic [7:0]        load_grey;
  logic              fwd_hit;
  logic [7:0]        map_grey;
  map_wr_t           map_wr;
  map_rd_t           map_rd;

  item_kind_t        s1_kind_r;
  logic [7:0]        s1_grey_r;
  logic [SUM_W-1:0]  s1_sum_r;
  logic [MAP_AW-1:0] s1_idx_r;
  logic              s1_fwd_r;
  logic [7:0]        s1_fwd_data_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [7:0]        out_grey_r;
  logic [7:0]        out_grey_nxt;

  gtg_cfg_regs u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .source_format (fmt)
  );

  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;
  assign acc           = in_chan.valid && adv;

  // classify the incoming item
  always_comb begin
    if (in_chan.func == FUNC_LOAD) begin
      kind = ({1'b0, in_chan.entry_index} < 9'(PALETTE_ENTRIES)) ? K_LOAD : K_NONE;
    end else begin
      unique case (fmt)
        FMT_INDEXED: kind = K_INDEX;
        FMT_RGB565:  kind = K_DIRECT;
        FMT_BGRA:    kind = K_DIRECT;
        default:     kind = K_NONE;
      endcase
    end
  end

  always_comb begin
    if (fmt == FMT_RGB565) begin
      r8 = {in_chan.pixel[15:11], 3'b000};
      g8 = {in_chan.pixel[10:5], 2'b00};
      b8 = {in_chan.pixel[4:0], 3'b000};
    end else begin
      r8 = in_chan.pixel[23:16];
      g8 = in_chan.pixel[15:8];
      b8 = in_chan.pixel[7:0];
    end
  end

  assign direct_sum = 9'(RED_TBL[r8]) + 9'(GREEN_TBL[g8]) + 9'(BLUE_TBL[b8]);

  assign load_sum = SUM_W'(in_chan.red)   * SUM_W'(W_RED)
                  + SUM_W'(in_chan.green) * SUM_W'(W_GREEN)
                  + SUM_W'(in_chan.blue)  * SUM_W'(W_BLUE);

  // divide the weighted sum by 1000 through the reciprocal
  assign prod      = PROD_W'(s1_sum_r) * PROD_W'(RECIP_K);
  assign load_grey = prod[RECIP_SH +: 8];

  // a load leaving stage 1 lands in the same edge the pixel reads: forward it
  assign fwd_hit = (s1_kind_r == K_LOAD) && (in_chan.pixel[MAP_AW-1:0] == s1_idx_r);

  assign map_wr.en   = adv && (s1_kind_r == K_LOAD);
  assign map_wr.addr = s1_idx_r;
  assign map_wr.data = load_grey;
  assign map_rd.en   = acc;
  assign map_rd.addr = in_chan.pixel[MAP_AW-1:0];

  gtg_map_store u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (map_wr),
    .rd      (map_rd),
    .rd_grey (map_grey)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_kind_r <= K_NONE;
    end else if (adv) begin
      s1_kind_r <= acc ? kind : K_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_grey_r     <= direct_sum[7:0];
      s1_sum_r      <= load_sum;
      s1_idx_r      <= in_chan.entry_index[MAP_AW-1:0];
      s1_fwd_r      <= fwd_hit;
      s1_fwd_data_r <= load_grey;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_grey_nxt  = out_grey_r;
    if (adv) begin
      out_valid_nxt = (s1_kind_r == K_DIRECT) || (s1_kind_r == K_INDEX);
      out_grey_nxt  = (s1_kind_r == K_INDEX) ? (s1_fwd_r ? s1_fwd_data_r : map_grey)
                                             : s1_grey_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_grey_r <= out_grey_nxt;
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.grey  = out_grey_r;

  `GTG_ASSERT_NXT(a_load_no_result, adv && (s1_kind_r == K_LOAD), !out_valid_r)
  `GTG_ASSERT_NXT(a_fwd_taken, acc && (kind == K_INDEX) && fwd_hit, s1_fwd_r)
  `GTG_ASSERT_NXT(a_undef_fmt_drop,
                  acc && (in_chan.func == FUNC_CONVERT) && (fmt == FMT_UNDEF),
                  s1_kind_r == K_NONE)
endmodule

FILE: rtl/core/gtg_cfg_regs.sv
// ---------------------------------------------------------------------------
// gtg_cfg_regs
// APB-style register file holding the source format.
// ---------------------------------------------------------------------------
module gtg_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gtg_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output gtg_pkg::src_fmt_t              source_format
);
  import gtg_pkg::*;

  src_fmt_t fmt_r;
  logic     sel_fmt;
  logic     wr_en;

  assign sel_fmt = (paddr[CFG_ADDR_W-1] == REG_IDX_SOURCE_FORMAT);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_BGRA;
    end else if (wr_en && sel_fmt) begin
      fmt_r <= src_fmt_t'(pwdata[1:0]);
    end
  end

  assign prdata        = sel_fmt ? {30'd0, fmt_r} : 32'd0;
  assign source_format = fmt_r;
endmodule

FILE: rtl/core/gtg_map_store.sv
// ---------------------------------------------------------------------------
// gtg_map_store
// Grey map memory with registered read and per-entry valid bits.
// ---------------------------------------------------------------------------
module gtg_map_store (
  input  logic             clk,
  input  logic             rst_n,
  input  gtg_pkg::map_wr_t wr,
  input  gtg_pkg::map_rd_t rd,
  output logic [7:0]       rd_grey
);
  import gtg_pkg::*;

  logic [7:0]           mem [MAP_DEPTH];
  logic [MAP_DEPTH-1:0] valid_r;
  logic [7:0]           rd_data_r;
  logic                 rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  // an entry never loaded reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_valid_r <= valid_r[rd.addr];
      end
    end
  end

  assign rd_grey = rd_valid_r ? rd_data_r : 8'd0;
endmodule

FILE: sim/greyscale_checker.sv
// ---------------------------------------------------------------------------
// greyscale_checker
// Watches the pixel, grey and register channels of the converter. It keeps
// its own palette grey table and source format, predicts the grey of each
// pixel accepted in a defined format and compares each grey item with the oldest due.
// ---------------------------------------------------------------------------
module greyscale_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  gtg_in_if                              in_mon,
  gtg_out_if                             out_mon,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [gtg_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output int                             mismatches,
  output int                             outstanding,
  output int                             compared
);
  import gtg_pkg::*;

  logic [7:0] luma_table [256];
  src_fmt_t   fmt;
  logic [7:0] grey_due [$];

  // per-channel floors, summed afterwards
  function automatic logic [7:0] weighted_grey(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return 8'((32'(r) * 299) / 1000 + (32'(g) * 587) / 1000 + (32'(b) * 114) / 1000);
  endfunction

  // one floor over the exact weighted sum
  function automatic logic [7:0] palette_grey(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return 8'((32'(r) * 299 + 32'(g) * 587 + 32'(b) * 114) / 1000);
  endfunction

  function automatic logic [7:0] pixel_grey(logic [31:0] px);
    case (fmt)
      FMT_INDEXED: return luma_table[px[7:0]];
      FMT_RGB565:  return weighted_grey({px[15:11], 3'b000}, {px[10:5], 2'b00},
                                        {px[4:0], 3'b000});
      default:     return weighted_grey(px[23:16], px[15:8], px[7:0]);
    endcase
  endfunction

  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst_n) begin
      foreach (luma_table[i]) luma_table[i] = 8'h00;
      fmt = FMT_BGRA;
      grey_due.delete();
      mismatches = 0;
      compared = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (grey_due.size() == 0) begin
          if (mismatches < 10) $display("unexpected grey item: got %0d", out_mon.grey);
          mismatches++;
        end else begin
          want = grey_due.pop_front();
          compared++;
          if (out_mon.grey !== want) begin
            if (mismatches < 10)
              $display("grey mismatch: expected %0d, got %0d", want, out_mon.grey);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.func == FUNC_LOAD) begin
          if (32'(in_mon.entry_index) < PALETTE_ENTRIES)
            luma_table[in_mon.entry_index] = palette_grey(in_mon.red, in_mon.green,
                                                          in_mon.blue);
        end else if (fmt != FMT_UNDEF) begin
          grey_due.push_back(pixel_grey(in_mon.pixel));
        end
      end
      // only the low two bits of the format register are kept
      if (psel && penable && pwrite && pready &&
          (paddr >> 2) == CFG_ADDR_W'(REG_IDX_SOURCE_FORMAT))
        fmt = src_fmt_t'(pwdata[1:0]);
    end
    outstanding = grey_due.size();
  end

endmodule

FILE: sim/tb.sv
// ---------------------------------------------------------------------------
// tb
// Drives palette loads, pixels and format register writes into the greyscale
// converter with random gaps and output stalls, including one long output
// hold-off, and reports the verdict from the checker's mismatch count.
// ---------------------------------------------------------------------------
module tb;
  import gtg_pkg::*;

  localparam int LIMIT = 100000;
  localparam logic [CFG_ADDR_W-1:0] ADDR_FORMAT   = CFG_ADDR_W'(4 * REG_IDX_SOURCE_FORMAT);
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED = CFG_ADDR_W'(4);
  localparam src_fmt_t PHASE_FMT [9] = '{FMT_BGRA, FMT_INDEXED, FMT_RGB565, FMT_UNDEF,
                                         FMT_INDEXED, FMT_BGRA, FMT_RGB565, FMT_INDEXED,
                                         FMT_BGRA};

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  logic calm;
  logic rx_hold;
  int   rx_wait;
  int   sent;
  int   cycle_count = 0;
  int   fail_count;
  int   pending;
  int   checked_count;

  gtg_in_if  in_chan ();
  gtg_out_if out_chan ();

  pixel_to_greyscale_converter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  greyscale_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (fail_count),
    .outstanding (pending),
    .compared    (checked_count)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("timeout after %0d cycles, %0d grey items still due", cycle_count, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // grey receiver: fresh stall drawn after every item, none drawn in calm stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_wait = 0;
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready)
        rx_wait = calm ? 0 : $urandom_range(0, 9);
      else if (rx_wait > 0)
        rx_wait--;
      out_chan.ready <= (rx_wait == 0) && !rx_hold;
    end
  end

  // hold the output off for a long stretch so the converter backs up
  initial begin
    rx_hold = 1'b0;
    wait (sent >= 150);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (150) @(posedge clk);
    rx_hold <= 1'b0;
  end

  function automatic logic [7:0] colour();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic send_item(logic f, logic [31:0] px, logic [7:0] idx,
                           logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.func        <= f;
    in_chan.pixel       <= px;
    in_chan.entry_index <= idx;
    in_chan.red         <= r;
    in_chan.green       <= g;
    in_chan.blue        <= b;
    do @(negedge clk); while (!in_chan.ready);
    @(posedge clk);
    sent++;
  endtask

  task automatic convert(logic [31:0] px);
    send_item(FUNC_CONVERT, px, 8'($urandom()), 8'($urandom()), 8'($urandom()),
              8'($urandom()));
  endtask

  task automatic load_entry(logic [7:0] idx, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    send_item(FUNC_LOAD, $urandom(), idx, r, g, b);
  endtask

  task automatic random_item(src_fmt_t f);
    logic [31:0] px;
    logic [7:0]  idx;
    bit          is_load;
    if (f == FMT_INDEXED || f == FMT_UNDEF)
      is_load = $urandom_range(0, 9) < 3;
    else
      is_load = $urandom_range(0, 9) == 0;
    px  = $urandom();
    idx = 8'($urandom());
    // keep most loads and indexed reads in a small window so they meet
    if ($urandom_range(0, 4) != 0) begin
      idx = 8'($urandom_range(0, 15));
      if (f == FMT_INDEXED) px[7:0] = 8'($urandom_range(0, 15));
    end
    if (is_load)
      load_entry(idx, colour(), colour(), colour());
    else
      send_item(FUNC_CONVERT, px, idx, colour(), colour(), colour());
  endtask

  // drop valid, drain the grey items due, then allow for the pipeline
  task automatic settle();
    in_chan.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    rst_n               = 1'b0;
    calm                = 1'b1;
    sent                = 0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_chan.valid       = 1'b0;
    in_chan.func        = FUNC_LOAD;
    in_chan.pixel       = '0;
    in_chan.entry_index = '0;
    in_chan.red         = '0;
    in_chan.green       = '0;
    in_chan.blue        = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // BGRA straight out of reset, alpha ignored
    convert(32'h0000_0000);
    convert(32'hFFFF_FFFF);
    convert(32'h00FF_0000);
    convert(32'h0000_FF00);
    convert(32'h0000_00FF);
    convert(32'hFF00_0000);

    settle();
    cfg_write(ADDR_FORMAT, 32'(FMT_INDEXED));
    convert(32'h0000_0012);           // table cleared by reset
    load_entry(8'h00, 8'hFF, 8'hFF, 8'hFF);
    load_entry(8'hFF, 8'hFF, 8'h00, 8'h00);
    load_entry(8'h80, 8'h00, 8'hFF, 8'h00);
    convert(32'hFFFF_FF00);           // upper bits ignored
    convert(32'h0000_00FF);
    load_entry(8'h01, 8'h00, 8'h00, 8'hFF);
    convert(32'h0000_0001);           // straight after its own load
    convert(32'h1234_5680);

    settle();
    cfg_write(ADDR_FORMAT, 32'hFFFF_FFFD);   // upper bits dropped: RGB565
    convert(32'h0000_FFFF);
    convert(32'h0000_0000);
    convert(32'h0000_F800);
    convert(32'h0000_07E0);
    convert(32'h0000_001F);
    convert(32'hFFFF_0000);

    settle();
    cfg_write(ADDR_FORMAT, 32'(FMT_UNDEF));
    convert($urandom());              // no grey item
    load_entry(8'h02, 8'h80, 8'h80, 8'h80);
    settle();
    cfg_write(ADDR_UNMAPPED, 32'(FMT_INDEXED));   // must leave the format alone
    convert(32'h0000_0002);
    settle();
    cfg_write(ADDR_FORMAT, 32'(FMT_INDEXED));
    convert(32'h0000_0002);           // load taken while format was undefined

    for (int ph = 0; ph < 9; ph++) begin
      settle();
      cfg_write(ADDR_FORMAT, ($urandom() & ~32'h3) | 32'(PHASE_FMT[ph]));
      if ($urandom_range(0, 2) == 0) cfg_write(ADDR_UNMAPPED, $urandom());
      calm <= ($urandom_range(0, 3) == 0);
      for (int n = 0; n < (PHASE_FMT[ph] == FMT_UNDEF ? 24 : 64); n++)
        random_item(PHASE_FMT[ph]);
    end
    settle();

    $display("%0d items sent, %0d grey items compared", sent, checked_count);
    $display("formats indexed, RGB565, BGRA and undefined, with one long output hold-off");
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/gtg_pkg.sv
rtl/core/gtg_in_if.sv
rtl/core/gtg_out_if.sv
rtl/core/gtg_cfg_regs.sv
rtl/core/gtg_map_store.sv
rtl/core/pixel_to_greyscale_converter.sv
sim/greyscale_checker.sv
sim/tb.sv
